// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the time converter.
// Depends on nothing; taken in by `include where a module asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, checked out of reset.
`define ASSERT_IMPL(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("implication check failed");

// Implication after a fixed number of cycles.
`define ASSERT_DELAY(lbl, clk, rstn, pre, dly, post) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> ##dly (post)) \
    else $error("delayed check failed");

`endif

// ===== rtl/utcgps_pkg.sv =====
// Constants and helper functions for the UTC / GPS time converter.
// No dependencies; used by utc_gps_time_converter.
`timescale 1ns / 1ps

package utcgps_pkg;

  localparam int LEAP_KNOWN = 18;

  // newest first: year, month, GPS minus UTC seconds; each starts on day 1
  localparam int LEAP_YR [LEAP_KNOWN] = '{2017, 2015, 2012, 2009, 2006, 1999, 1997, 1996,
                                          1994, 1993, 1992, 1991, 1990, 1988, 1985, 1983,
                                          1982, 1981};
  localparam int LEAP_MO [LEAP_KNOWN] = '{1, 7, 7, 1, 1, 1, 7, 1, 7, 7, 7, 1, 1, 1, 7, 7,
                                          7, 7};
  localparam int LEAP_OFF [LEAP_KNOWN] = '{18, 17, 16, 15, 14, 13, 12, 11, 10, 9, 8, 7,
                                           6, 5, 4, 3, 2, 1};

  localparam logic [34:0] EPOCH_SEC  = 35'd315964800;  // 1980-01-06 since 1970
  localparam logic [19:0] SEC_WEEK   = 20'd604800;
  localparam logic [19:0] SEC_DAY    = 20'd86400;
  localparam logic [10:0] DAYS_CYCLE = 11'd1461;
  localparam logic [11:0] YEAR_BASE  = 12'd1970;
  localparam logic [11:0] YEAR_LAST  = 12'd2099;

  // reciprocals: week on (g >> 7) / 4725, day on (t >> 7) / 675
  localparam logic [26:0] RCP_WEEK  = 27'd58175219;
  localparam logic [26:0] RCP_DAY   = 27'd101806633;
  localparam logic [16:0] RCP_CYCLE = 17'd91868;   // / 1461, shift 27
  localparam logic [13:0] RCP_HOUR  = 14'd9321;    // (x >> 4) / 225, shift 21
  localparam logic [10:0] RCP_MIN   = 11'd1093;    // (x >> 2) / 15, shift 14

  // zero-based day of year at which a month starts, common year
  function automatic logic [8:0] month_start(logic [3:0] mon);
    logic [8:0] r;
    unique case (mon)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // seconds since 1970 at which a leap table row takes effect
  function automatic longint leap_start(int idx);
    longint y;
    longint m;
    longint d;
    y = longint'(LEAP_YR[idx]);
    m = longint'(LEAP_MO[idx]);
    d = (y - 1970) * 365 + (y - 1969) / 4 + longint'(month_start(4'(m)));
    if ((y % 4) == 0 && m >= 3) d = d + 1;
    return d * 86400;
  endfunction

endpackage

// ===== rtl/utc_gps_time_converter.sv =====
// Top level of the UTC calendar <-> GPS week / time-of-week converter.
// Depends on utcgps_pkg and assert_macros.svh.
//
// Usage:
//   Raise start_i with the command and its fields; the transfer is taken
//   at that edge since busy_o stays low (the pipeline takes one item per
//   cycle). Command 0 converts UTC calendar time to GPS week and seconds
//   of week, command 1 does the reverse; microseconds pass through,
//   saturated at 999999.
//   Each item gives one result: done_o is high for exactly one cycle
//   with the result ports valid in that cycle. Throughput is one item
//   per cycle; the pipeline has ten register stages (day count, seconds,
//   leap table search, leap fix-up, reciprocal divide, remainder, then
//   the calendar split).
//   The receiver cannot stall, so results are never held back.
//   Reset clears all stage valid bits; items in flight are dropped.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utc_gps_time_converter #(
  parameter int LEAP_ENTRIES = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_of_month_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  input  logic [19:0] microsecond_i,
  input  logic [12:0] gps_week_i,
  input  logic [19:0] week_seconds_i,
  output logic        done_o,
  output logic        valid_res_o,
  output logic [12:0] out_week_o,
  output logic [19:0] out_week_seconds_o,
  output logic [19:0] out_microsecond_o,
  output logic [11:0] out_year_o,
  output logic [3:0]  out_month_o,
  output logic [4:0]  out_day_o,
  output logic [4:0]  out_hour_o,
  output logic [5:0]  out_minute_o,
  output logic [5:0]  out_second_o
);

  localparam int NSTG = 10;

  logic        accept;
  logic [NSTG-1:1] v_q;
  logic [NSTG-1:1] cmd_q;
  logic [NSTG-1:1] inv_q;     // command 0 result flagged invalid
  logic [19:0] us_q [NSTG-1:1];

  // stage 1
  logic signed [17:0] days1_d, days1_q;
  logic [16:0] tod1_d, tod1_q;
  logic [34:0] tg1_d, tg1_q;
  logic        bad1_d;
  logic [19:0] us1_d;
  // stage 2 to 4
  logic signed [34:0] t2_d, t2_q, t3_q, a4_d, a4_q;
  logic [4:0]  off3_d, off3_q;
  // stage 5 and 6
  logic [52:0] prod5;
  logic [15:0] q5_d, q5_q, q6_q, q7_q, q8_q, q9_q;
  logic [32:0] a5_q;
  logic [35:0] prod6;
  logic [19:0] r6_d, r6_q, r7_q, r8_q, r9_q;
  // stage 7 to 9 (calendar)
  logic [32:0] prod7c;
  logic [26:0] prod7h;
  logic [5:0]  q4_7_q, q4_8_q, q4_9_q;
  logic [4:0]  hr7_q, hr8_q, hr9_q;
  logic [10:0] dcyc8_d, dcyc8_q;
  logic [11:0] remh8_d, remh8_q, remh9_q;
  logic [1:0]  yc9_d, yc9_q;
  logic [8:0]  doy9_d, doy9_q;
  logic [20:0] prod9m;
  logic [5:0]  min9_q;
  // output stage
  logic [3:0]  mon10;
  logic [8:0]  cum10;
  logic [11:0] yr10;
  logic [5:0]  sec10;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // stage 1: day count and time of day, or GPS seconds since 1970
  always_comb begin
    logic [7:0]  yo;
    logic [16:0] sum;
    logic        adj;
    yo     = 8'(year_i - utcgps_pkg::YEAR_BASE);
    bad1_d = (year_i < utcgps_pkg::YEAR_BASE) || (year_i > utcgps_pkg::YEAR_LAST) ||
             (month_i < 4'd1) || (month_i > 4'd12);
    adj    = (yo[1:0] == 2'd2) && (month_i >= 4'd3);
    sum    = 17'(yo) * 17'd365 + 17'((9'(yo) + 9'd1) >> 2) +
             17'(utcgps_pkg::month_start(month_i)) + 17'(day_of_month_i) + 17'(adj);
    days1_d = $signed({1'b0, sum}) - 18'sd1;
    tod1_d  = 17'(hour_i) * 17'd3600 + 17'(minute_i) * 17'd60 + 17'(second_i);
    tg1_d   = utcgps_pkg::EPOCH_SEC + 35'(gps_week_i) * 35'(utcgps_pkg::SEC_WEEK) +
              35'(week_seconds_i);
    us1_d   = (microsecond_i > 20'd999999) ? 20'd999999 : microsecond_i;
  end

  // stage 2: seconds since 1970
  assign t2_d = cmd_q[1] ? $signed(tg1_q)
                         : 35'(days1_q) * 35'sd86400 + $signed({18'b0, tod1_q});

  // stage 3: newest applicable leap row
  always_comb begin
    off3_d = '0;
    for (int i = utcgps_pkg::LEAP_KNOWN - 1; i >= 0; i--) begin
      if (i < LEAP_ENTRIES) begin
        if (cmd_q[2]) begin
          if (t2_q >= $signed(35'(utcgps_pkg::leap_start(i) + utcgps_pkg::LEAP_OFF[i])))
            off3_d = 5'(utcgps_pkg::LEAP_OFF[i]);
        end else begin
          if (t2_q >= $signed(35'(utcgps_pkg::leap_start(i))))
            off3_d = 5'(utcgps_pkg::LEAP_OFF[i]);
        end
      end
    end
  end

  // stage 4: apply leap seconds; command 0 moves to the GPS epoch
  assign a4_d = cmd_q[3] ? t3_q - $signed({30'b0, off3_q})
                         : t3_q + $signed({30'b0, off3_q}) - $signed(utcgps_pkg::EPOCH_SEC);

  // stage 5: quotient by week or by day through one shared multiplier
  assign prod5 = 53'(a4_q[32:7]) * 53'(cmd_q[4] ? utcgps_pkg::RCP_DAY : utcgps_pkg::RCP_WEEK);
  assign q5_d  = cmd_q[4] ? prod5[51:36] : {3'b0, prod5[50:38]};

  // stage 6: remainder
  assign prod6 = 36'(q5_q) * 36'(cmd_q[5] ? utcgps_pkg::SEC_DAY : utcgps_pkg::SEC_WEEK);
  assign r6_d  = 20'(36'(a5_q) - prod6);

  // stage 7: four-year cycles and hours
  assign prod7c = 33'(q6_q) * 33'(utcgps_pkg::RCP_CYCLE);
  assign prod7h = 27'(r6_q[16:4]) * 27'(utcgps_pkg::RCP_HOUR);

  // stage 8: day within cycle, seconds within hour
  assign dcyc8_d = 11'(q7_q - 16'(q4_7_q) * 16'(utcgps_pkg::DAYS_CYCLE));
  assign remh8_d = 12'(r7_q - 20'(hr7_q) * 20'd3600);

  // stage 9: year within cycle (third year is the leap year), minutes
  always_comb begin
    priority if (dcyc8_q >= 11'd1096) begin
      yc9_d = 2'd3; doy9_d = 9'(dcyc8_q - 11'd1096);
    end else if (dcyc8_q >= 11'd730) begin
      yc9_d = 2'd2; doy9_d = 9'(dcyc8_q - 11'd730);
    end else if (dcyc8_q >= 11'd365) begin
      yc9_d = 2'd1; doy9_d = 9'(dcyc8_q - 11'd365);
    end else begin
      yc9_d = 2'd0; doy9_d = 9'(dcyc8_q);
    end
  end
  assign prod9m = 21'(remh8_q[11:2]) * 21'(utcgps_pkg::RCP_MIN);

  // stage 10: month walk, day, second and year
  always_comb begin
    logic [8:0] s;
    mon10 = 4'd1;
    cum10 = '0;
    for (int k = 1; k <= 12; k++) begin
      s = utcgps_pkg::month_start(4'(k)) + 9'((yc9_q == 2'd2) && (k >= 3));
      if (doy9_q >= s) begin
        mon10 = 4'(k);
        cum10 = s;
      end
    end
    sec10 = 6'(remh9_q - 12'(min9_q) * 12'd60);
    yr10  = utcgps_pkg::YEAR_BASE + 12'({q4_9_q, 2'b00}) + 12'(yc9_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      done_o <= 1'b0;
    end else begin
      v_q    <= {v_q[NSTG-2:1], accept};
      done_o <= v_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q[1] <= command_i;
    inv_q[1] <= bad1_d;
    us_q[1]  <= us1_d;
    for (int s = 2; s < NSTG; s++) begin
      cmd_q[s] <= cmd_q[s-1];
      us_q[s]  <= us_q[s-1];
      if (s != 4) inv_q[s] <= inv_q[s-1];
    end
    // flag command 0 instants before the GPS epoch
    inv_q[4] <= inv_q[3] || (!cmd_q[3] && a4_d < 0);
    days1_q <= days1_d;
    tod1_q  <= tod1_d;
    tg1_q   <= tg1_d;
    t2_q    <= t2_d;
    t3_q    <= t2_q;
    off3_q  <= off3_d;
    a4_q    <= a4_d;
    q5_q    <= q5_d;
    a5_q    <= a4_q[32:0];
    q6_q    <= q5_q;
    r6_q    <= r6_d;
    q7_q    <= q6_q;
    r7_q    <= r6_q;
    q4_7_q  <= prod7c[32:27];
    hr7_q   <= prod7h[25:21];
    q8_q    <= q7_q;
    r8_q    <= r7_q;
    q4_8_q  <= q4_7_q;
    hr8_q   <= hr7_q;
    dcyc8_q <= dcyc8_d;
    remh8_q <= remh8_d;
    q9_q    <= q8_q;
    r9_q    <= r8_q;
    q4_9_q  <= q4_8_q;
    hr9_q   <= hr8_q;
    yc9_q   <= yc9_d;
    doy9_q  <= doy9_d;
    remh9_q <= remh8_q;
    min9_q  <= prod9m[19:14];

    out_microsecond_o <= us_q[NSTG-1];
    if (cmd_q[NSTG-1]) begin
      valid_res_o        <= yr10 <= utcgps_pkg::YEAR_LAST;
      out_week_o         <= '0;
      out_week_seconds_o <= '0;
      out_year_o         <= yr10;
      out_month_o        <= mon10;
      out_day_o          <= 5'(doy9_q - cum10 + 9'd1);
      out_hour_o         <= hr9_q;
      out_minute_o       <= min9_q;
      out_second_o       <= sec10;
    end else begin
      valid_res_o        <= !inv_q[NSTG-1];
      out_week_o         <= inv_q[NSTG-1] ? '0 : q9_q[12:0];
      out_week_seconds_o <= inv_q[NSTG-1] ? '0 : r9_q;
      out_year_o         <= '0;
      out_month_o        <= '0;
      out_day_o          <= '0;
      out_hour_o         <= '0;
      out_minute_o       <= '0;
      out_second_o       <= '0;
    end
  end

  `ASSERT_DELAY(a_latency, clk_i, rst_ni, accept, 10, done_o)
  `ASSERT_IMPL(a_week_range, clk_i, rst_ni, done_o, out_week_seconds_o < 20'd604800)
  `ASSERT_IMPL(a_tod_range, clk_i, rst_ni, done_o,
               out_hour_o < 5'd24 && out_minute_o < 6'd60 && out_second_o < 6'd60)
  `ASSERT_IMPL(a_cal_range, clk_i, rst_ni, done_o && out_year_o != 12'd0,
               out_month_o >= 4'd1 && out_month_o <= 4'd12 && out_day_o >= 5'd1)
  `ASSERT_IMPL(a_side_zero, clk_i, rst_ni, done_o && out_year_o != 12'd0,
               out_week_o == 13'd0 && out_week_seconds_o == 20'd0)

endmodule
